[src/iddt_pkg.sv]
// ----------------------------------------------------------------------------
// iddt_pkg
// Shared widths, codes and types for the incremental difference-table checker.
// ----------------------------------------------------------------------------
package iddt_pkg;

    // s-box input width and derived sizes
    localparam int IN_BITS  = 8;
    localparam int PT_W     = IN_BITS;
    localparam int VAL_W    = 8;
    localparam int D_W      = (IN_BITS > VAL_W) ? IN_BITS : VAL_W;
    localparam int NPOINTS  = 1 << IN_BITS;

    // pair table packing: several 2-bit counts per memory word
    localparam int CNT_W     = 2;
    localparam int LANE_W    = 3;
    localparam int LANES     = 1 << LANE_W;
    localparam int WORD_W    = CNT_W * LANES;
    localparam int TBL_AW    = IN_BITS + VAL_W - LANE_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    typedef logic [1:0]       op_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // operation codes
    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;
    localparam op_t OP_NONE   = 2'd3;

    localparam cnt_t COUNT_MAX = 2'd3;
    localparam cnt_t COUNT_ONE = 2'd1;

endpackage

[src/iddt_ram.sv]
// ----------------------------------------------------------------------------
// iddt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module iddt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[src/incremental_ddt_apn_checker.sv]
// ----------------------------------------------------------------------------
// incremental_ddt_apn_checker
// Partial s-box plus pair-count table; add/remove walks earlier points and
// reports whether any (input diff, output diff) entry breaks the apn bound.
// ----------------------------------------------------------------------------
//  channel   | ports                              | transfer
//  ----------+------------------------------------+-----------------------------
//  command   | start, operation, point, value     | start high while busy low
//  result    | done, still_apn                    | done high, one cycle
//  config    | cfg_we, cfg_data                   | cfg_we high
//
//  add: skips an earlier point at odd-weight input difference, and runs the
//  table read-modify-write (S_SREAD, S_UPD) for an even-weight one; remove
//  first fetches the stored value (S_LOADC); stops early on failure.
//  clear: one table word per cycle, 2^(IN_BITS+5) words (8192 at 8 bits).
//  after reset the same sweep runs with busy high before the first transfer.
//  results cannot be stalled; done pulses for one cycle.
module incremental_ddt_apn_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  iddt_pkg::op_t             operation,
    input  logic [7:0]                point,
    input  logic [iddt_pkg::VAL_W-1:0] value,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_data,
    output logic                      done,
    output logic                      still_apn
);
    import iddt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADC = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        range_base_reg;
    logic [PT_W-1:0]   c_reg, c_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [VAL_W-1:0]  sc_reg, sc_next;
    logic              rem_reg, rem_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [TBL_AW-1:0] taddr_reg, taddr_next;
    logic [TBL_AW-1:0] clr_reg, clr_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic              done_reg, done_next;
    logic              apn_reg, apn_next;

    logic              sbox_we;
    logic [PT_W-1:0]   sbox_addr;
    logic [VAL_W-1:0]  sbox_rdata;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_addr;
    logic [WORD_W-1:0] tbl_wdata;
    logic [WORD_W-1:0] tbl_rdata;

    logic [PT_W-1:0]   di;
    logic [VAL_W-1:0]  dout;
    logic              in_take;
    cnt_t              cnt_old;
    cnt_t              cnt_new;
    logic              cnt_fail;

    assign in_take = start && (state_reg == S_IDLE);
    assign di      = c_reg ^ d_reg[PT_W-1:0];
    assign dout    = sc_reg ^ sbox_rdata;

    // s-box store: written on add, read for the point and each earlier point
    assign sbox_we   = in_take && (operation == OP_ADD);
    assign sbox_addr = (state_reg == S_IDLE) ? point[PT_W-1:0] : d_reg[PT_W-1:0];

    iddt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NPOINTS)
    ) u_sbox (
        .clk   (clk),
        .we    (sbox_we),
        .addr  (sbox_addr),
        .wdata (value),
        .rdata (sbox_rdata)
    );

    // count update for the selected lane
    always_comb
    begin
        cnt_old = tbl_rdata[lane_reg*CNT_W +: CNT_W];
        if (rem_reg)
        begin
            cnt_new  = (cnt_old != '0) ? cnt_old - 1'b1 : cnt_old;
            cnt_fail = (cnt_new == COUNT_ONE);
        end
        else
        begin
            cnt_new  = (cnt_old != COUNT_MAX) ? cnt_old + 1'b1 : cnt_old;
            cnt_fail = (cnt_new > COUNT_ONE);
        end
    end

    // pair table port: sweep writes, walk read-modify-write
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_addr  = taddr_reg;
        tbl_wdata = tbl_rdata;
        case (state_reg)
            S_CLR:
            begin
                tbl_we    = 1'b1;
                tbl_addr  = clr_reg;
                tbl_wdata = '0;
            end
            S_SREAD:
            begin
                tbl_addr = {di, dout[VAL_W-1:LANE_W]};
            end
            S_UPD:
            begin
                tbl_we = 1'b1;
                tbl_wdata[lane_reg*CNT_W +: CNT_W] = cnt_new;
            end
            default:
            begin
                tbl_addr = taddr_reg;
            end
        endcase
    end

    iddt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        sc_next      = sc_reg;
        rem_next     = rem_reg;
        lane_next    = lane_reg;
        taddr_next   = taddr_reg;
        clr_next     = clr_reg;
        clr_rsp_next = clr_rsp_reg;
        done_next    = 1'b0;
        apn_next     = apn_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    c_next   = point[PT_W-1:0];
                    d_next   = D_W'(range_base_reg);
                    sc_next  = value;
                    rem_next = (operation == OP_REMOVE);
                    case (operation)
                        OP_ADD:    state_next = S_SCAN;
                        OP_REMOVE: state_next = S_LOADC;
                        OP_CLEAR:
                        begin
                            clr_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            apn_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_LOADC:
            begin
                sc_next    = sbox_rdata;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (d_reg >= D_W'(c_reg))
                begin
                    done_next  = 1'b1;
                    apn_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (^di)
                begin
                    d_next = d_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SREAD;
                end
            end
            S_SREAD:
            begin
                lane_next  = dout[LANE_W-1:0];
                taddr_next = {di, dout[VAL_W-1:LANE_W]};
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (cnt_fail)
                begin
                    done_next  = 1'b1;
                    apn_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    done_next    = clr_rsp_reg;
                    apn_next     = 1'b1;
                    clr_rsp_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            clr_rsp_reg    <= 1'b0;
            done_reg       <= 1'b0;
            apn_reg        <= 1'b1;
            range_base_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_rsp_reg <= clr_rsp_next;
            done_reg    <= done_next;
            apn_reg     <= apn_next;
            if (cfg_we)
            begin
                range_base_reg <= cfg_data;
            end
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        d_reg     <= d_next;
        sc_reg    <= sc_next;
        rem_reg   <= rem_next;
        lane_reg  <= lane_next;
        taddr_reg <= taddr_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign still_apn = apn_reg;

endmodule

[src/iddt_checker.sv]
// ----------------------------------------------------------------------------
// iddt_checker
// Port-level checks on the command and result handshake of the checker.
// ----------------------------------------------------------------------------
module iddt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input iddt_pkg::op_t              operation,
    input logic                       done,
    input logic                       still_apn
);
    import iddt_pkg::*;

    // a result only shows while the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a result follows a busy cycle or a transfer
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a command");

    // every transfer leads to work or to an immediate result
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command dropped");

    // busy only rises on a transfer
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a command");

    // the unused operation answers with a pass
    a_none_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_NONE)) |=> (done && still_apn))
        else $error("unused operation did not pass");

endmodule

bind incremental_ddt_apn_checker iddt_checker u_iddt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done),
    .still_apn (still_apn)
);

[bench/incremental_ddt_apn_checker_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_ddt_apn_checker_check
// Watches the command, result and config channels of the apn checker, keeps
// its own copy of the partial s-box and pair table, and compares every
// still_apn result against the prediction for the oldest open command.
// ----------------------------------------------------------------------------
module incremental_ddt_apn_checker_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  iddt_pkg::op_t               operation,
    input  logic [7:0]                  point,
    input  logic [iddt_pkg::VAL_W-1:0]  value,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_data,
    input  logic                        done,
    input  logic                        still_apn,
    output int unsigned                 mismatch_count,
    output int unsigned                 results_owed
);
    import iddt_pkg::*;

    typedef struct {
        op_t        op;
        logic [7:0] pt;
        bit         apn;
    } apn_verdict_t;

    // model state: s-box copy, pair counts indexed by {input diff, output diff}
    logic [VAL_W-1:0] sbox_copy [0:NPOINTS-1];
    cnt_t             pair_table [0:NPOINTS*256-1];
    logic [7:0]       range_base;
    apn_verdict_t     verdict_queue [$];
    apn_verdict_t     oldest;

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // walk earlier points of equal parity, bumping (grow) or dropping counts
    function automatic bit walk_pairs(logic [PT_W-1:0] c, bit grow);
        int               d;
        logic [PT_W-1:0]  din;
        logic [VAL_W-1:0] dout;
        cnt_t             cnt;
        for (d = int'(range_base); d < int'(c); d++) begin
            din = c ^ d[PT_W-1:0];
            if (^din == 1'b0) begin
                dout = sbox_copy[c] ^ sbox_copy[d];
                cnt  = pair_table[{din, dout}];
                if (grow) begin
                    // saturate at three pairs, fail on anything above one
                    if (cnt < COUNT_MAX)
                        cnt = cnt + 1'b1;
                    pair_table[{din, dout}] = cnt;
                    if (cnt > COUNT_ONE)
                        return 1'b0;
                end
                else begin
                    // never drop below zero, stop when back at one pair
                    if (cnt != '0)
                        cnt = cnt - 1'b1;
                    pair_table[{din, dout}] = cnt;
                    if (cnt == COUNT_ONE)
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic bit predict_apn(op_t op, logic [7:0] pt, logic [VAL_W-1:0] val);
        case (op)
            OP_ADD:
            begin
                sbox_copy[pt] = val;
                return walk_pairs(pt, 1'b1);
            end
            OP_REMOVE:
                return walk_pairs(pt, 1'b0);
            OP_CLEAR:
            begin
                foreach (pair_table[i])
                    pair_table[i] = '0;
                return 1'b1;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    // channel monitor: config, result transfer, command transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (pair_table[i])
                pair_table[i] = '0;
            range_base = '0;
            verdict_queue.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_we)
                range_base = cfg_data;

            // result transfer
            if (done)
            begin
                if (verdict_queue.size() == 0)
                    note_mismatch($sformatf("result still_apn=%0b with no command open",
                                            still_apn));
                else
                begin
                    oldest = verdict_queue.pop_front();
                    if (still_apn !== oldest.apn)
                        note_mismatch($sformatf("op %0d point %0d: still_apn expected %0b, got %0b",
                                                oldest.op, oldest.pt, oldest.apn,
                                                still_apn));
                end
            end

            // command transfer
            if (start && !busy)
            begin
                oldest.op  = operation;
                oldest.pt  = point;
                oldest.apn = predict_apn(operation, point, value);
                verdict_queue.push_back(oldest);
            end
            results_owed = verdict_queue.size();
        end
    end

endmodule

[bench/incremental_ddt_apn_checker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_ddt_apn_checker_test
// Drives add, remove, clear and unused commands into the apn checker across
// several range_base settings and sender idle rates; a separate checker module
// predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module incremental_ddt_apn_checker_test;
    import iddt_pkg::*;

    localparam int PHASE_ITEMS  = 350;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 1000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    op_t              operation;
    logic [7:0]       point;
    logic [VAL_W-1:0] value;
    logic             cfg_we;
    logic [7:0]       cfg_data;
    logic             done;
    logic             still_apn;
    int unsigned      mismatch_count;
    int unsigned      results_owed;

    // points written so far, so no walk ever reads an unwritten s-box entry
    bit               filled [0:NPOINTS-1];
    int               base_copy;
    int               cursor;
    int               idle_pct;
    int               cycle_count;
    logic [7:0]       phase_base [0:3];
    int               phase_idle [0:3];

    incremental_ddt_apn_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .point     (point),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .done      (done),
        .still_apn (still_apn)
    );

    incremental_ddt_apn_checker_check apn_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .point          (point),
        .value          (value),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .still_apn      (still_apn),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("incremental_ddt_apn_checker_test NOT OK");
        $finish;
    end

    // true when every equal-parity earlier point in range has been written
    function automatic bit walk_is_safe(op_t op, int c);
        int d;
        if (op == OP_REMOVE && !filled[c])
            return 1'b0;
        for (d = base_copy; d < c; d++)
            if (^(c[7:0] ^ d[7:0]) == 1'b0 && !filled[d])
                return 1'b0;
        return 1'b1;
    endfunction

    // one command transfer, with random sender gaps before it
    task automatic issue(op_t op, logic [7:0] pt, logic [VAL_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        point     <= pt;
        value     <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_ADD)
            filled[pt] = 1'b1;
    endtask

    // config write once the block has gone quiet
    task automatic write_range_base(logic [7:0] b);
        @(negedge clk);
        start <= 1'b0;
        while (results_owed != 0 || busy)
            @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= b;
        @(negedge clk);
        cfg_we    <= 1'b0;
        base_copy = int'(b);
        cursor    = int'(b);
    endtask

    // mostly a growing s-box with backtracking, plus random legal noise
    task automatic random_item();
        int               pick;
        op_t              op;
        logic [7:0]       pt;
        logic [VAL_W-1:0] val;
        pick = int'($urandom_range(0, 99));
        pt   = 8'($urandom_range(0, 255));
        val  = VAL_W'($urandom_range(0, 255));
        if (cursor > NPOINTS - 1)
        begin
            // s-box full: wipe the table and grow it again
            op     = OP_CLEAR;
            cursor = base_copy;
        end
        else if (pick < 50)
        begin
            op = OP_ADD;
            pt = cursor[7:0];
            cursor++;
        end
        else if (pick < 60 && cursor > base_copy)
        begin
            // undo the newest point so it is retried with another value
            cursor--;
            op = OP_REMOVE;
            pt = cursor[7:0];
        end
        else if (pick < 70)
        begin
            op = OP_ADD;
            if (!walk_is_safe(op, int'(pt)))
            begin
                pt = cursor[7:0];
                cursor++;
            end
        end
        else if (pick < 80)
        begin
            op = OP_REMOVE;
            if (!walk_is_safe(op, int'(pt)))
            begin
                if (cursor > base_copy)
                    pt = 8'($urandom_range(base_copy, cursor - 1));
                else
                begin
                    op = OP_ADD;
                    pt = cursor[7:0];
                    cursor++;
                end
            end
        end
        else if (pick < 90 && cursor > base_copy)
        begin
            // overwrite an already grown point
            op = OP_ADD;
            pt = 8'($urandom_range(base_copy, cursor - 1));
        end
        else if (pick < 98)
            op = OP_NONE;
        else
            op = OP_CLEAR;
        issue(op, pt, val);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_NONE;
        point     = '0;
        value     = '0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        base_copy = 0;
        cursor    = 0;
        idle_pct  = 0;
        foreach (filled[i])
            filled[i] = 1'b0;
        phase_base[0] = 8'd128;
        phase_base[1] = 8'd0;
        phase_base[2] = 8'($urandom_range(1, 127));
        phase_base[3] = 8'd127;
        phase_idle[0] = 0;
        phase_idle[1] = 86;
        phase_idle[2] = 17;
        phase_idle[3] = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: lower half
        write_range_base(8'd0);
        issue(OP_NONE, 8'hFF, 8'hFF);
        issue(OP_ADD, 8'd0, 8'h00);
        issue(OP_ADD, 8'd1, 8'hFF);
        issue(OP_ADD, 8'd2, 8'h01);
        // same (3, fe) pair as points 1 and 2: apn broken
        issue(OP_ADD, 8'd3, 8'hFE);
        // back to one pair, then full undo, then removal from an empty entry
        issue(OP_REMOVE, 8'd3, 8'h00);
        issue(OP_REMOVE, 8'd3, 8'h00);
        issue(OP_REMOVE, 8'd3, 8'h00);
        // climb one entry to three pairs and past it
        repeat (4) issue(OP_ADD, 8'd3, 8'hFE);
        issue(OP_CLEAR, 8'hAA, 8'h55);
        issue(OP_ADD, 8'd3, 8'hFE);
        issue(OP_REMOVE, 8'd0, 8'h00);

        // directed: upper half
        write_range_base(8'd128);
        issue(OP_ADD, 8'd128, 8'h80);
        issue(OP_ADD, 8'd129, 8'h7F);
        issue(OP_ADD, 8'd130, 8'h81);
        issue(OP_REMOVE, 8'd3, 8'h00);
        issue(OP_REMOVE, 8'd130, 8'h00);
        issue(OP_CLEAR, 8'h55, 8'hAA);
        issue(OP_NONE, 8'h00, 8'h00);

        // random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            write_range_base(phase_base[ph]);
            idle_pct = phase_idle[ph];
            repeat (PHASE_ITEMS) random_item();
        end

        // drain
        @(negedge clk);
        start <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("incremental_ddt_apn_checker_test OK");
        else
            $display("incremental_ddt_apn_checker_test NOT OK");
        $finish;
    end

endmodule
